### rtl/core/feistel_block_cipher_64_assert.svh
// Assertion macros used by the cipher round module.
// Both macros sample on clock; the first is masked while reset is high.
`ifndef FEISTEL_BLOCK_CIPHER_64_ASSERT_SVH
`define FEISTEL_BLOCK_CIPHER_64_ASSERT_SVH

`define FBC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`define FBC_ASSERT_NEXT_RST(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/core/fbc_pkg.sv
`default_nettype none

package fbc_pkg;

   localparam int WORD_W            = 32;
   localparam int BLOCK_W           = 64;
   localparam int ROUND_COUNT_DFLT  = 16;
   localparam int KEY_ROT           = 5;

   localparam logic [WORD_W-1:0]  ROUND_ADD = 32'h9E3779B9;
   localparam logic [WORD_W-1:0]  ROUND_MUL = 32'h85EBCA6B;
   localparam logic [BLOCK_W-1:0] SCHED_ADD = 64'h9E3779B97F4A7C15;

   // Control that travels alongside each block through the round stages.
   typedef struct packed {
      logic valid;
      logic decrypt;
   } stage_ctrl_type;

   function automatic logic [BLOCK_W-1:0] rotl64(input logic [BLOCK_W-1:0] v,
                                                 input int amount);
      int s;
      s = amount % BLOCK_W;
      return (v << s) | (v >> (BLOCK_W - s));
   endfunction

   // The running schedule key after round idx equals the master key rotated
   // left by 5*(idx+1) XORed with a constant; this returns that constant.
   // It is only ever called with elaboration-time arguments.
   function automatic logic [BLOCK_W-1:0] sched_offset(input int idx);
      logic [BLOCK_W-1:0] d;
      d = '0;
      for (int j = 0; j <= idx; j++) begin
         d = rotl64(d, KEY_ROT) ^ (SCHED_ADD + BLOCK_W'(j));
      end
      return d;
   endfunction

endpackage

`default_nettype wire

### rtl/core/feistel_block_cipher_64.sv
// 64-bit Feistel block cipher, fully pipelined.
// Configuration: csr_valid/csr_ready write the 64-bit master key; csr_ready is
// always high. Write the key only while no block is in flight.
// Request channel: req_valid with req_operation (0 encrypt, 1 decrypt) and
// req_data_block (left word in bits 63..32). A transfer takes place when
// req_valid is high and req_stall is low.
// Response channel: rsp_valid with rsp_result_block; a transfer takes place
// when rsp_valid is high and rsp_stall is low.
// Each round occupies two register stages (key mix and add, then multiply and
// mix). One block may enter every cycle while the pipeline is not stalled;
// the subkeys are derived from the key register by fixed rotations and
// constants.
// When the receiver stalls a waiting response, the whole pipeline holds and
// req_stall rises in the same cycle; nothing is lost or repeated.
// Synchronous reset empties the pipeline and clears the key to zero.
`default_nettype none

module feistel_block_cipher_64
   import fbc_pkg::*;
#(
   parameter int ROUND_COUNT = ROUND_COUNT_DFLT
)
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [BLOCK_W-1:0]  csr_cipher_key,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_operation,
   input  wire logic [BLOCK_W-1:0]  req_data_block,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [BLOCK_W-1:0]       rsp_result_block
);

   logic [BLOCK_W-1:0] key_ff;
   logic               advance;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         key_ff <= csr_cipher_key;
      end
   end

   // Round subkeys: each is a fixed rotation of the key XORed with a constant.
   logic [WORD_W-1:0] sub_key [ROUND_COUNT];

   for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_sched
      localparam logic [BLOCK_W-1:0] Offset = sched_offset(g);
      logic [BLOCK_W-1:0] rot_key;
      assign rot_key    = rotl64(key_ff, KEY_ROT * (g + 1)) ^ Offset;
      assign sub_key[g] = rot_key[WORD_W-1:0];
   end

   // The pipeline moves unless a finished block is waiting on the receiver.
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   stage_ctrl_type    ctrl  [ROUND_COUNT+1];
   logic [WORD_W-1:0] word_l[ROUND_COUNT+1];
   logic [WORD_W-1:0] word_r[ROUND_COUNT+1];

   assign ctrl[0].valid   = req_valid;
   assign ctrl[0].decrypt = req_operation;
   assign word_l[0]       = req_data_block[BLOCK_W-1:WORD_W];
   assign word_r[0]       = req_data_block[WORD_W-1:0];

   for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
      fbc_round u_round (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .in_ctrl  (ctrl[g]),
         .in_l     (word_l[g]),
         .in_r     (word_r[g]),
         .enc_key  (sub_key[g]),
         .dec_key  (sub_key[ROUND_COUNT-1-g]),
         .out_ctrl (ctrl[g+1]),
         .out_l    (word_l[g+1]),
         .out_r    (word_r[g+1])
      );
   end

   assign rsp_valid        = ctrl[ROUND_COUNT].valid;
   assign rsp_result_block = {word_l[ROUND_COUNT], word_r[ROUND_COUNT]};

endmodule

`default_nettype wire

### rtl/core/fbc_round.sv
`default_nettype none
`include "feistel_block_cipher_64_assert.svh"

module fbc_round
   import fbc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire stage_ctrl_type      in_ctrl,
   input  wire logic [WORD_W-1:0]   in_l,
   input  wire logic [WORD_W-1:0]   in_r,
   input  wire logic [WORD_W-1:0]   enc_key,
   input  wire logic [WORD_W-1:0]   dec_key,
   output stage_ctrl_type           out_ctrl,
   output logic [WORD_W-1:0]        out_l,
   output logic [WORD_W-1:0]        out_r
);

   // Stage A: key mix, rotations, add and the first xor-shift.
   stage_ctrl_type    a_ctrl_ff;
   logic [WORD_W-1:0] a_x_ff, a_x_in;
   logic [WORD_W-1:0] a_src_ff, a_oth_ff;
   logic [WORD_W-1:0] src, oth, key, x0, x1, x2, x3;

   // Encryption feeds the right word through F, decryption the left word.
   assign src = in_ctrl.decrypt ? in_l : in_r;
   assign oth = in_ctrl.decrypt ? in_r : in_l;
   assign key = in_ctrl.decrypt ? dec_key : enc_key;

   always_comb begin
      x0     = src ^ key;
      x1     = {x0[WORD_W-4:0], x0[WORD_W-1:WORD_W-3]};
      x2     = x1 ^ {x1[WORD_W-8:0], x1[WORD_W-1:WORD_W-7]};
      x3     = x2 + ROUND_ADD;
      a_x_in = x3 ^ (x3 >> 16);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctrl_ff <= '0;
      end else if (advance) begin
         a_ctrl_ff <= in_ctrl;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_x_ff   <= a_x_in;
         a_src_ff <= src;
         a_oth_ff <= oth;
      end
   end

   // Stage B: constant multiply, final xor-shift and the Feistel mix.
   stage_ctrl_type    b_ctrl_ff;
   logic [WORD_W-1:0] b_l_ff, b_r_ff, b_l_in, b_r_in;
   logic [WORD_W-1:0] prod, f_out, mixed;

   always_comb begin
      prod  = a_x_ff * ROUND_MUL;
      f_out = prod ^ (prod >> 13);
      mixed = a_oth_ff ^ f_out;
      if (a_ctrl_ff.decrypt) begin
         b_l_in = mixed;
         b_r_in = a_src_ff;
      end else begin
         b_l_in = a_src_ff;
         b_r_in = mixed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ctrl_ff <= '0;
      end else if (advance) begin
         b_ctrl_ff <= a_ctrl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_l_ff <= b_l_in;
         b_r_ff <= b_r_in;
      end
   end

   assign out_ctrl = b_ctrl_ff;
   assign out_l    = b_l_ff;
   assign out_r    = b_r_ff;

   `FBC_ASSERT_NEXT_RST(a_rst_clear, reset, !a_ctrl_ff.valid && !b_ctrl_ff.valid)
   `FBC_ASSERT_NEXT(a_takes_item, advance && in_ctrl.valid, a_ctrl_ff.valid)
   `FBC_ASSERT_NEXT(b_takes_item, advance && a_ctrl_ff.valid, b_ctrl_ff.valid)
   `FBC_ASSERT_NEXT(b_holds, !advance, $stable(b_ctrl_ff) && $stable(b_l_ff) && $stable(b_r_ff))

endmodule

`default_nettype wire

### sim/tb_feistel_block_cipher_64.sv
module tb_feistel_block_cipher_64
   import fbc_pkg::*;
();

   localparam int                 NUM_ROUNDS   = 16;
   localparam logic [31:0]        MIX_ADD      = 32'h9E3779B9;
   localparam logic [31:0]        MIX_MUL      = 32'h85EBCA6B;
   localparam logic [63:0]        KEY_STEP     = 64'h9E3779B97F4A7C15;
   localparam int                 HOLD_CYCLES  = 300;
   localparam int                 TAIL_CYCLES  = 48;
   localparam int                 RANDOM_PER_PHASE = 225;

   typedef enum bit {OP_ENCRYPT = 1'b0, OP_DECRYPT = 1'b1} cipher_op_type;

   typedef struct {
      cipher_op_type        op;
      logic [BLOCK_W-1:0]   blk;
   } block_req_type;

   typedef struct {
      cipher_op_type        op;
      logic [BLOCK_W-1:0]   blk;
      logic [BLOCK_W-1:0]   want;
   } block_exp_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [BLOCK_W-1:0]  csr_cipher_key = '0;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_operation = 1'b0;
   logic [BLOCK_W-1:0]  req_data_block = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [BLOCK_W-1:0]  rsp_result_block;

   block_req_type       pending_blocks[$];
   block_exp_type       expected_blocks[$];
   logic [BLOCK_W-1:0]  key_shadow = '0;
   int                  send_idle_pct = 0;
   int                  recv_idle_pct = 0;
   logic                sender_pause = 1'b0;
   logic                hold_kick = 1'b0;
   int                  hold_left = 0;
   int                  fail_count = 0;
   int                  report_count = 0;

   feistel_block_cipher_64 u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_cipher_key   (csr_cipher_key),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_data_block   (req_data_block),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_block (rsp_result_block)
   );

   always #5 clock = ~clock;

   function automatic logic [31:0] round_mix(input logic [31:0] x, input logic [31:0] k);
      x = x ^ k;
      x = {x[28:0], x[31:29]};
      x = x ^ {x[24:0], x[31:25]};
      x = x + MIX_ADD;
      x = x ^ (x >> 16);
      x = x * MIX_MUL;
      x = x ^ (x >> 13);
      return x;
   endfunction

   function automatic logic [BLOCK_W-1:0] cipher_expect(input cipher_op_type op,
                                                        input logic [BLOCK_W-1:0] blk,
                                                        input logic [BLOCK_W-1:0] key);
      logic [31:0]        sub [NUM_ROUNDS];
      logic [BLOCK_W-1:0] run;
      logic [31:0]        lw;
      logic [31:0]        rw;
      logic [31:0]        tmp;
      run = key;
      for (int i = 0; i < NUM_ROUNDS; i++) begin
         run = {run[58:0], run[63:59]} ^ (KEY_STEP + 64'(i));
         sub[i] = run[31:0];
      end
      lw = blk[63:32];
      rw = blk[31:0];
      if (op == OP_ENCRYPT) begin
         for (int i = 0; i < NUM_ROUNDS; i++) begin
            tmp = rw;
            rw  = lw ^ round_mix(rw, sub[i]);
            lw  = tmp;
         end
      end else begin
         for (int i = NUM_ROUNDS - 1; i >= 0; i--) begin
            tmp = lw;
            lw  = rw ^ round_mix(lw, sub[i]);
            rw  = tmp;
         end
      end
      return {lw, rw};
   endfunction

   // Mostly uniform blocks, with some half-empty, half-full, single-bit and single-zero-bit ones.
   function automatic logic [BLOCK_W-1:0] rand_block();
      logic [BLOCK_W-1:0] b;
      b = {$urandom, $urandom};
      case ($urandom_range(0, 11))
         8: begin
            b[63:32] = '0;
         end
         9: begin
            b[31:0] = '1;
         end
         10: begin
            b = 64'h1 << $urandom_range(0, 63);
         end
         11: begin
            b = ~(64'h1 << $urandom_range(0, 63));
         end
         default: begin
         end
      endcase
      return b;
   endfunction

   // Driver: a new block is offered only once the previous one has transferred.
   always @(posedge clock) begin : drive_requests
      block_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_blocks.push_back('{cipher_op_type'(req_operation), req_data_block,
               cipher_expect(cipher_op_type'(req_operation), req_data_block, key_shadow)});
         end
         if (!req_valid || !req_stall) begin
            if (pending_blocks.size() != 0 && !sender_pause &&
                $urandom_range(0, 99) >= send_idle_pct) begin
               nxt = pending_blocks.pop_front();
               req_valid      <= 1'b1;
               req_operation  <= nxt.op;
               req_data_block <= nxt.blk;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : count_hold
      if (reset) begin
         hold_left <= 0;
      end else if (hold_kick) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin : check_results
      block_exp_type exp_blk;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_blocks.size() == 0) begin
               fail_count++;
               if (report_count < 10) begin
                  report_count++;
                  $display("unexpected result %h at %0t", rsp_result_block, $realtime);
               end
            end else begin
               exp_blk = expected_blocks.pop_front();
               if (rsp_result_block !== exp_blk.want) begin
                  fail_count++;
                  if (report_count < 10) begin
                     report_count++;
                     $display("result_block mismatch: op %s block %h expected %h got %h",
                              exp_blk.op.name(), exp_blk.blk, exp_blk.want,
                              rsp_result_block);
                  end
               end
            end
         end
         rsp_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   task automatic queue_item(input cipher_op_type op, input logic [BLOCK_W-1:0] blk);
      pending_blocks.push_back('{op, blk});
   endtask

   task automatic drain_all();
      do @(negedge clock);
      while (pending_blocks.size() != 0 || req_valid || expected_blocks.size() != 0);
   endtask

   task automatic write_key(input logic [BLOCK_W-1:0] k);
      @(posedge clock);
      csr_valid      <= 1'b1;
      csr_cipher_key <= k;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid  <= 1'b0;
      key_shadow = k;
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      @(negedge clock);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   // Random blocks, a good share of them an encryption followed by the
   // decryption of its ciphertext, so that round trips are exercised.
   task automatic queue_random(input int n);
      int                 made;
      logic [BLOCK_W-1:0] plain;
      made = 0;
      while (made < n) begin
         if ($urandom_range(0, 9) >= 6) begin
            plain = rand_block();
            queue_item(OP_ENCRYPT, plain);
            queue_item(OP_DECRYPT, cipher_expect(OP_ENCRYPT, plain, key_shadow));
            made += 2;
         end else begin
            queue_item(cipher_op_type'($urandom_range(0, 1)), rand_block());
            made += 1;
         end
      end
   endtask

   task automatic queue_extremes();
      queue_item(OP_ENCRYPT, 64'h0);
      queue_item(OP_DECRYPT, 64'h0);
      queue_item(OP_ENCRYPT, '1);
      queue_item(OP_DECRYPT, '1);
      queue_item(OP_ENCRYPT, 64'h8000_0000_0000_0001);
      queue_item(OP_DECRYPT, 64'h0000_0000_FFFF_FFFF);
   endtask

   initial begin : run_phases
      logic [BLOCK_W-1:0] phase_key [6];
      phase_key[0] = 64'h8000_0000_0000_0000;
      phase_key[1] = 64'h0000_0000_0000_0001;
      phase_key[2] = {$urandom, $urandom};
      phase_key[3] = {$urandom, $urandom};
      phase_key[4] = '1;
      phase_key[5] = {$urandom, $urandom};

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed blocks under the reset key, which has never been written.
      set_idling(17, 75);
      queue_extremes();
      queue_item(OP_ENCRYPT, 64'hFFFF_FFFF_0000_0000);
      queue_item(OP_ENCRYPT, 64'hAAAA_AAAA_AAAA_AAAA);
      queue_item(OP_DECRYPT, 64'h5555_5555_5555_5555);
      queue_item(OP_ENCRYPT, 64'h0123_4567_89AB_CDEF);
      queue_item(OP_DECRYPT, cipher_expect(OP_ENCRYPT, 64'h0123_4567_89AB_CDEF, key_shadow));
      drain_all();

      write_key('1);
      queue_extremes();
      drain_all();

      write_key('0);
      queue_extremes();
      drain_all();

      for (int p = 0; p < 6; p++) begin
         if (p < 2) begin
            set_idling(17, 75);
         end else if (p < 4) begin
            set_idling(75, 17);
         end else begin
            set_idling(0, 0);
         end
         write_key(phase_key[p]);
         @(negedge clock);
         queue_random(RANDOM_PER_PHASE);
         if (p == 4) begin
            // The receiver holds off for a long stretch while blocks keep
            // coming, so the pipeline fills and the request side stalls.
            hold_kick = 1'b1;
            @(negedge clock);
            hold_kick = 1'b0;
         end
         if (p == 5) begin
            while (pending_blocks.size() > RANDOM_PER_PHASE / 2) @(negedge clock);
            sender_pause = 1'b1;
            while (req_valid || expected_blocks.size() != 0) @(negedge clock);
            sender_pause = 1'b0;
         end
         drain_all();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      fail_count += expected_blocks.size();
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin : watchdog
      #3000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/fbc_pkg.sv
rtl/core/fbc_round.sv
rtl/core/feistel_block_cipher_64.sv
sim/tb_feistel_block_cipher_64.sv
